// ----- rtl/core/pip_pkg.sv -----
// pip_pkg: types and constants shared by the point-in-convex-polygon block
// used by pip_vertex_ram, pip_cross_unit and point_in_convex_polygon_top
// no dependencies
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS       = 16;
  localparam int DIFF_BITS        = COORD_BITS + 1;
  localparam int PROD_BITS        = 2 * DIFF_BITS;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] LOC_INSIDE   = 2'd0;
  localparam logic [1:0] LOC_BOUNDARY = 2'd1;
  localparam logic [1:0] LOC_OUTSIDE  = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
  } pip_in_t;

  typedef struct packed {
    logic       status;
    logic [1:0] location;
    logic [6:0] vertices_held;
  } pip_out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } vertex_t;

  // sign of a cross product
  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ORG_RD,
    S_ORG_LD,
    S_RD,
    S_MUL,
    S_SGN
  } state_t;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_MID,
    PH_FIN
  } phase_t;

endpackage

// ----- rtl/core/pip_vertex_ram.sv -----
// pip_vertex_ram: single-port-write, single-port-read vertex memory
// registered read data; uses pip_pkg
module pip_vertex_ram
  import pip_pkg::*;
#(
  parameter int DEPTH = MAX_VERTICES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  vertex_t       wr_data,
  input  logic [AW-1:0] rd_addr,
  output vertex_t       rd_data
);

  vertex_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/pip_cross_unit.sv -----
// pip_cross_unit: exact sign of cross(tgt - org, q - org)
// products registered, subtract and sign in the following cycle; uses pip_pkg
module pip_cross_unit
  import pip_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  vertex_t org,
  input  vertex_t tgt,
  input  vertex_t q,
  output sign_t   sign
);

  logic signed [DIFF_BITS-1:0] ex, ey, qx, qy;
  logic signed [PROD_BITS-1:0] p1, p2;
  logic signed [PROD_BITS:0]   cross_val;

  assign ex = DIFF_BITS'(tgt.x) - DIFF_BITS'(org.x);
  assign ey = DIFF_BITS'(tgt.y) - DIFF_BITS'(org.y);
  assign qx = DIFF_BITS'(q.x) - DIFF_BITS'(org.x);
  assign qy = DIFF_BITS'(q.y) - DIFF_BITS'(org.y);

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= ex * qy;
      p2 <= ey * qx;
    end
  end

  assign cross_val = (PROD_BITS + 1)'(p1) - (PROD_BITS + 1)'(p2);
  assign sign.neg  = cross_val[PROD_BITS];
  assign sign.zero = (cross_val == '0);

endmodule

// ----- rtl/core/point_in_convex_polygon_top.sv -----
// point_in_convex_polygon_top: vertex store with clear, append and point query
// uses pip_pkg, pip_vertex_ram, pip_cross_unit
//
// Takes one command transaction when start is high and busy is low, and gives
// exactly one result, on result for one cycle with done high; the result cannot
// be stalled, so a user must take it in that cycle. Clear, append and any other
// command answer on the cycle after acceptance. A query on fewer than three
// vertices answers likewise; otherwise each cross-product test reads the single
// read port of the vertex memory, then passes through a multiply state and a
// sign state; a query tests the fan edges from vertex 0, then narrows the wedge
// by binary search and ends with a final edge test, stopping early when the fan
// test against vertex 0 already shows the point is out. busy stays high over the
// whole query. A new command may be accepted in the cycle in which done is high.
module point_in_convex_polygon_top
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  pip_in_t  item,
  output logic     done,
  output pip_out_t result
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  state_t        state, state_next;
  phase_t        phase, phase_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] org_addr, org_addr_next;
  logic [AW-1:0] tgt, tgt_next;
  logic [AW-1:0] lo, lo_next;
  logic [AW-1:0] hi, hi_next;
  logic          a_zero, a_zero_next;
  logic          b_zero, b_zero_next;
  vertex_t       q, q_next;
  vertex_t       org, org_next;
  logic          done_next;
  pip_out_t      result_next;

  logic          mem_we;
  logic [AW-1:0] rd_addr;
  vertex_t       mem_q;
  vertex_t       wr_data;
  logic          mul_en;
  sign_t         sgn;

  logic [AW-1:0] last;
  logic [AW-1:0] srch_lo, srch_hi;
  logic [AW:0]   srch_sum;

  assign wr_data.x = COORD_BITS'(item.coord_x);
  assign wr_data.y = COORD_BITS'(item.coord_y);
  assign last      = AW'(count - CW'(1));

  pip_vertex_ram #(
    .DEPTH(MAX_VERTICES)
  ) u_ram (
    .clk    (clk),
    .we     (mem_we),
    .wr_addr(count[AW-1:0]),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(mem_q)
  );

  pip_cross_unit u_cross (
    .clk (clk),
    .en  (mul_en),
    .org (org),
    .tgt (mem_q),
    .q   (q),
    .sign(sgn)
  );

  // bounds of the wedge search after this sign, mid is held in tgt
  always_comb begin
    if (phase == PH_B) begin
      srch_lo = AW'(1);
      srch_hi = last;
    end else if (!sgn.neg) begin
      srch_lo = tgt;
      srch_hi = hi;
    end else begin
      srch_lo = lo;
      srch_hi = tgt;
    end
    srch_sum = (AW + 1)'(srch_lo) + (AW + 1)'(srch_hi);
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    count_next    = count;
    org_addr_next = org_addr;
    tgt_next      = tgt;
    lo_next       = lo;
    hi_next       = hi;
    a_zero_next   = a_zero;
    b_zero_next   = b_zero;
    q_next        = q;
    org_next      = org;
    done_next     = 1'b0;
    result_next   = result;
    mem_we        = 1'b0;
    mul_en        = 1'b0;
    rd_addr       = tgt;
    busy          = (state != S_IDLE);

    case (state)
      S_IDLE: begin
        if (start) begin
          q_next               = wr_data;
          result_next.status   = STATUS_OK;
          result_next.location = LOC_INSIDE;
          done_next            = 1'b1;
          case (item.cmd)
            CMD_CLEAR: begin
              count_next = '0;
            end
            CMD_APPEND: begin
              if (count < CW'(MAX_VERTICES)) begin
                mem_we     = 1'b1;
                count_next = count + CW'(1);
              end else begin
                result_next.status = STATUS_DROPPED;
              end
            end
            CMD_QUERY: begin
              if (count < CW'(3)) begin
                result_next.location = LOC_OUTSIDE;
              end else begin
                done_next     = 1'b0;
                org_addr_next = '0;
                tgt_next      = AW'(1);
                phase_next    = PH_A;
                state_next    = S_ORG_RD;
              end
            end
            default: begin
            end
          endcase
          result_next.vertices_held = 7'(count_next);
        end
      end
      S_ORG_RD: begin
        rd_addr    = org_addr;
        state_next = S_ORG_LD;
      end
      S_ORG_LD: begin
        org_next   = mem_q;
        state_next = S_MUL;
      end
      S_RD: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        mul_en     = 1'b1;
        state_next = S_SGN;
      end
      S_SGN: begin
        result_next.status        = STATUS_OK;
        result_next.vertices_held = 7'(count);
        case (phase)
          PH_A: begin
            a_zero_next = sgn.zero;
            if (sgn.neg) begin
              result_next.location = LOC_OUTSIDE;
              done_next            = 1'b1;
              state_next           = S_IDLE;
            end else begin
              tgt_next   = last;
              phase_next = PH_B;
              state_next = S_RD;
            end
          end
          PH_B, PH_MID: begin
            if (phase == PH_B) begin
              b_zero_next = sgn.zero;
            end
            lo_next = srch_lo;
            hi_next = srch_hi;
            if (phase == PH_B && !sgn.neg && !sgn.zero) begin
              result_next.location = LOC_OUTSIDE;
              done_next            = 1'b1;
              state_next           = S_IDLE;
            end else if ((AW + 1)'(srch_lo) + (AW + 1)'(1) < (AW + 1)'(srch_hi)) begin
              tgt_next   = srch_sum[AW:1];
              phase_next = PH_MID;
              state_next = S_RD;
            end else begin
              // final edge test from v[lo] to v[hi]
              org_addr_next = srch_lo;
              tgt_next      = srch_hi;
              phase_next    = PH_FIN;
              state_next    = S_ORG_RD;
            end
          end
          PH_FIN: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
            if (sgn.neg) begin
              result_next.location = LOC_OUTSIDE;
            end else if (sgn.zero) begin
              result_next.location = LOC_BOUNDARY;
            end else if ((lo == AW'(1) && a_zero) || (hi == last && b_zero)) begin
              result_next.location = LOC_BOUNDARY;
            end else begin
              result_next.location = LOC_INSIDE;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_A;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    org_addr <= org_addr_next;
    tgt      <= tgt_next;
    lo       <= lo_next;
    hi       <= hi_next;
    a_zero   <= a_zero_next;
    b_zero   <= b_zero_next;
    q        <= q_next;
    org      <= org_next;
    result   <= result_next;
  end

endmodule
